// ----- rtl/ipid_pkg.sv -----
// Package: shared widths, register indexes, operation codes and sequencer states.
package ipid_pkg;

    localparam int DRIVE_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int TIME_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(DRIVE_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DER_TIME  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_ONLY = 2'd3;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_MULG  = 3'd4;
    localparam logic [2:0] S_WAITP = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- rtl/ipid_mul.sv -----
// Bit-serial shift-add multiplier, product modulo 2^32, one multiplier bit per cycle.
module ipid_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ipid_pkg::DRIVE_W-1:0]  i_a,
    input  logic [ipid_pkg::DRIVE_W-1:0]  i_b,
    output ipid_pkg::t_unit_sts           o_sts,
    output logic [ipid_pkg::DRIVE_W-1:0]  o_p
);

    logic [ipid_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ipid_pkg::DRIVE_W-1:0] r_a, n_a;
    logic [ipid_pkg::DRIVE_W-1:0] r_b, n_b;
    logic [ipid_pkg::DRIVE_W-1:0] r_p, n_p;

    always_comb begin
        n_cnt = r_cnt;
        n_a   = r_a;
        n_b   = r_b;
        n_p   = r_p;
        if (i_start) begin
            n_cnt = ipid_pkg::CNT_W'(ipid_pkg::DRIVE_W);
            n_a   = i_a;
            n_b   = i_b;
            n_p   = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (r_b[0]) begin
                n_p = r_p + r_a;
            end
            n_a = {r_a[ipid_pkg::DRIVE_W-2:0], 1'b0};
            n_b = {1'b0, r_b[ipid_pkg::DRIVE_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_p <= n_p;
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = (r_cnt == ipid_pkg::CNT_W'(1));
    assign o_p        = r_p;

endmodule

// ----- rtl/ipid_div.sv -----
// Bit-serial restoring divider: signed 32-bit dividend by unsigned 24-bit divisor, truncating.
module ipid_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ipid_pkg::DRIVE_W-1:0]  i_dividend,
    input  logic [ipid_pkg::TIME_W-1:0]   i_divisor,
    output ipid_pkg::t_unit_sts           o_sts,
    output logic [ipid_pkg::DRIVE_W-1:0]  o_q
);

    logic [ipid_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ipid_pkg::DRIVE_W-1:0] r_num, n_num;
    logic [ipid_pkg::TIME_W-1:0]  r_rem, n_rem;
    logic [ipid_pkg::TIME_W-1:0]  r_den, n_den;
    logic                         r_neg, n_neg;
    logic [ipid_pkg::TIME_W:0]    w_trial;
    logic [ipid_pkg::TIME_W:0]    w_diff;

    assign w_trial = {r_rem, r_num[ipid_pkg::DRIVE_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_cnt = r_cnt;
        n_num = r_num;
        n_rem = r_rem;
        n_den = r_den;
        n_neg = r_neg;
        if (i_start) begin
            n_cnt = ipid_pkg::CNT_W'(ipid_pkg::DRIVE_W);
            n_neg = i_dividend[ipid_pkg::DRIVE_W-1];
            n_num = i_dividend[ipid_pkg::DRIVE_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_rem = '0;
            n_den = (i_divisor == '0) ? ipid_pkg::TIME_W'(1) : i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!w_diff[ipid_pkg::TIME_W]) begin
                n_rem = w_diff[ipid_pkg::TIME_W-1:0];
                n_num = {r_num[ipid_pkg::DRIVE_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[ipid_pkg::TIME_W-1:0];
                n_num = {r_num[ipid_pkg::DRIVE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = (r_cnt == ipid_pkg::CNT_W'(1));
    assign o_q        = r_neg ? (~r_num + 1'b1) : r_num;

endmodule

// ----- rtl/integer_pid_controller_top.sv -----
// Top level: integer PID regulator with trapezoidal integral, serial divide and multiply.
//
//  channel   dir  handshake                 content
//  s stream  in   i_s_tvalid / o_s_tready   tdata: set_point, measured_value; tuser: operation
//  m stream  out  o_m_tvalid / i_m_tready   tdata: drive
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat at a time. A clear passes S_EVAL and S_FIN; proportional-only adds the gain
// multiply; a full step runs the divide overlapped with the derivative multiply, then
// the gain multiply on the shared multiplier.
// Synchronous active-low reset clears control and state; gain and integral time reset to 1.
// A finished result waits in the output register; the next beat is taken meanwhile and
// its result is held back until the register frees.
module integer_pid_controller_top #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [VALUE_WIDTH-1:0] set_point, [2*VALUE_WIDTH-1:VALUE_WIDTH] measured_value, zero fill
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    // [0] operation
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [31:0] drive
    output logic [ipid_pkg::DRIVE_W-1:0]        o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ipid_pkg::TIME_W-1:0]         i_cfg_data
);

    localparam int EW = VALUE_WIDTH + 1;
    localparam int DW = ipid_pkg::DRIVE_W;

    logic [2:0]                    r_state, n_state;
    logic [ipid_pkg::GAIN_W-1:0]   r_gain;
    logic [ipid_pkg::TIME_W-1:0]   r_int_time;
    logic [ipid_pkg::TIME_W-1:0]   r_der_time;
    logic                          r_prop_only;
    logic                          r_op;
    logic [VALUE_WIDTH-1:0]        r_set, r_meas;
    logic [EW-1:0]                 r_err, n_err;
    logic [EW-1:0]                 r_prev, n_prev;
    logic [DW-1:0]                 r_integ, n_integ;
    logic [EW:0]                   r_diff, n_diff;
    logic [DW-1:0]                 r_sum, n_sum;
    logic [DW-1:0]                 r_res, n_res;
    logic                          r_out_valid, n_out_valid;
    logic [DW-1:0]                 r_drive, n_drive;

    logic                          w_s_acc, w_m_acc;
    logic [EW:0]                   w_pair, w_pair_adj;
    logic [EW-1:0]                 w_half;
    logic [EW-1:0]                 w_err;
    logic                          w_mul_start, w_div_start;
    logic [DW-1:0]                 w_mul_a, w_mul_b, w_mul_p, w_div_q;
    ipid_pkg::t_unit_sts           w_mul_sts, w_div_sts;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_m_acc     = r_out_valid && i_m_tready;
    assign o_s_tready  = (r_state == ipid_pkg::S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_drive;
    assign o_cfg_ready = 1'b1;

    assign w_err = {r_set[VALUE_WIDTH-1], r_set} - {r_meas[VALUE_WIDTH-1], r_meas};
    assign w_pair     = {w_err[EW-1], w_err} + {r_prev[EW-1], r_prev};
    assign w_pair_adj = w_pair + {{EW{1'b0}}, w_pair[EW]};
    assign w_half     = w_pair_adj[EW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= ipid_pkg::GAIN_W'(1);
            r_int_time  <= ipid_pkg::TIME_W'(1);
            r_der_time  <= '0;
            r_prop_only <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipid_pkg::CFG_GAIN:      r_gain      <= i_cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_INT_TIME:  r_int_time  <= i_cfg_data;
                ipid_pkg::CFG_DER_TIME:  r_der_time  <= i_cfg_data;
                ipid_pkg::CFG_PROP_ONLY: r_prop_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_prev      = r_prev;
        n_integ     = r_integ;
        n_diff      = r_diff;
        n_sum       = r_sum;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_drive     = r_drive;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = {{(DW-ipid_pkg::TIME_W){1'b0}}, r_der_time};
        w_mul_b     = {{(DW-EW-1){r_diff[EW]}}, r_diff};

        if (w_m_acc) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ipid_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_state = ipid_pkg::S_EVAL;
                end
            end
            ipid_pkg::S_EVAL: begin
                n_err = w_err;
                if (r_op == ipid_pkg::OP_CLEAR) begin
                    n_integ = '0;
                    n_prev  = '0;
                    n_res   = '0;
                    n_state = ipid_pkg::S_FIN;
                end else if (r_prop_only) begin
                    n_prev  = w_err;
                    n_sum   = {{(DW-EW){w_err[EW-1]}}, w_err};
                    n_state = ipid_pkg::S_MULG;
                end else begin
                    n_integ = r_integ + {{(DW-EW){w_half[EW-1]}}, w_half};
                    n_diff  = {w_err[EW-1], w_err} - {r_prev[EW-1], r_prev};
                    n_prev  = w_err;
                    n_state = ipid_pkg::S_START;
                end
            end
            ipid_pkg::S_START: begin
                w_mul_start = 1'b1;
                w_div_start = 1'b1;
                n_state     = ipid_pkg::S_WAIT;
            end
            ipid_pkg::S_WAIT: begin
                if (!w_mul_sts.busy && !w_div_sts.busy) begin
                    n_sum   = {{(DW-EW){r_err[EW-1]}}, r_err} + w_div_q + w_mul_p;
                    n_state = ipid_pkg::S_MULG;
                end
            end
            ipid_pkg::S_MULG: begin
                w_mul_start = 1'b1;
                w_mul_a     = {{(DW-ipid_pkg::GAIN_W){r_gain[ipid_pkg::GAIN_W-1]}}, r_gain};
                w_mul_b     = r_sum;
                n_state     = ipid_pkg::S_WAITP;
            end
            ipid_pkg::S_WAITP: begin
                if (w_mul_sts.done) begin
                    n_state = ipid_pkg::S_FIN;
                end
            end
            ipid_pkg::S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_drive     = (r_op == ipid_pkg::OP_CLEAR) ? r_res : w_mul_p;
                    n_out_valid = 1'b1;
                    n_state     = ipid_pkg::S_IDLE;
                end
            end
            default: n_state = ipid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipid_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            r_integ     <= n_integ;
        end
        if (w_s_acc) begin
            r_op   <= i_s_tuser;
            r_set  <= i_s_tdata[VALUE_WIDTH-1:0];
            r_meas <= i_s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
        end
        r_err   <= n_err;
        r_diff  <= n_diff;
        r_sum   <= n_sum;
        r_res   <= n_res;
        r_drive <= n_drive;
    end

    ipid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_p     (w_mul_p)
    );

    ipid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_integ),
        .i_divisor  (r_int_time),
        .o_sts      (w_div_sts),
        .o_q        (w_div_q)
    );

endmodule

// ----- rtl/ipid_chk.sv -----
// Port-level checker for the PID regulator, bound to the top level.
module ipid_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                o_s_tready,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [ipid_pkg::DRIVE_W-1:0]        o_m_tdata
);

    logic [1:0] r_pend, n_pend;
    logic       w_in, w_out;

    assign w_in  = i_s_tvalid && o_s_tready;
    assign w_out = o_m_tvalid && i_m_tready;

    always_comb begin
        n_pend = r_pend;
        if (w_in && !w_out) begin
            n_pend = r_pend + 1'b1;
        end else if (!w_in && w_out) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in |=> !o_s_tready)
        else $error("input ready right after an accepted beat");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out |-> r_pend != 2'd0)
        else $error("result beat without an input beat");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two beats outstanding");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind integer_pid_controller_top ipid_chk u_ipid_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
